[rtl/srpb_pkg.sv]
// Shared types, constants and helper functions of the skyline row pointer builder.
package srpb_pkg;

  localparam int NODE_COUNT    = 4096;
  localparam int NODE_W        = $clog2(NODE_COUNT);
  localparam int ELEMENT_NODES = 32;
  localparam int ELEM_W        = $clog2(ELEMENT_NODES);
  localparam int CNT_W         = ELEM_W + 1;
  localparam int MAX_DOFS      = 6;

  localparam int INNER_W = 13;
  localparam int DOFS_W  = 3;
  localparam int REACH_W = 12;
  localparam int PTR_W   = 32;
  localparam int ROW_W   = 15;
  localparam int WIDE_W  = 16;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_INNER_NODES   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOFS_PER_NODE = 1'd1;

  typedef struct packed {
    logic              action;
    logic [NODE_W-1:0] node_index;
    logic              element_end;
  } in_req_t;

  typedef struct packed {
    logic [PTR_W-1:0] row_pointer;
    logic [ROW_W-1:0] dof_row;
    logic             last;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLOSE,
    ST_EM_READ,
    ST_EM_MUL,
    ST_EM_ROW,
    ST_EM_LAST
  } state_t;

  function automatic logic [INNER_W-1:0] eff_inner(input logic [INNER_W-1:0] n);
    logic [INNER_W-1:0] r;
    r = n;
    if (n == '0) r = INNER_W'(1);
    else if (n > INNER_W'(NODE_COUNT)) r = INNER_W'(NODE_COUNT);
    return r;
  endfunction

  function automatic logic [DOFS_W-1:0] eff_dofs(input logic [DOFS_W-1:0] d);
    logic [DOFS_W-1:0] r;
    r = d;
    if (d == '0) r = DOFS_W'(1);
    else if (d > DOFS_W'(MAX_DOFS)) r = DOFS_W'(MAX_DOFS);
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] sat_add(input logic [PTR_W-1:0] a,
                                               input logic [WIDE_W-1:0] b);
    logic [PTR_W:0] s;
    s = {1'b0, a} + (PTR_W+1)'(b);
    return s[PTR_W] ? {PTR_W{1'b1}} : s[PTR_W-1:0];
  endfunction

endpackage

[rtl/skyline_row_pointer_builder.sv]
// Skyline row pointer builder: reach memory, element close walk and row pointer emission.
// Flow: a node entry is buffered while idle; an element end then walks the buffer
//   (one buffered node per cycle through the reach memory, read then write back).
// An emit request reads reach, multiplies, then sends one row per cycle, the last inner
//   node also the closing pointer; rows wait on out_stall, one output register.
// Reset: synchronous active-low; afterwards a clearing pass zeroes every entry of the reach
//   memory while in_stall stays high (configuration writes are still taken).
module skyline_row_pointer_builder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  srpb_pkg::in_req_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output srpb_pkg::out_req_t                out_data,
  input  logic                              cfg_we,
  input  logic [srpb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srpb_pkg::CFG_W-1:0]        cfg_wdata
);
  import srpb_pkg::*;

  // ---------------------------------------------------------------- state
  state_t state_r, state_nxt;

  logic [INNER_W-1:0] inner_nodes_r;
  logic [DOFS_W-1:0]  dofs_r;

  // reach memory, one entry per node
  logic [REACH_W-1:0] reach_mem [NODE_COUNT];
  logic [REACH_W-1:0] mem_rdata_r;
  logic               mem_we, mem_re;
  logic [NODE_W-1:0]  mem_wa, mem_ra;
  logic [REACH_W-1:0] mem_wd;

  logic [NODE_W-1:0]  clr_r;

  // element buffer: nodes of the element in progress
  logic [NODE_W-1:0]  elem_buf [ELEMENT_NODES];
  logic [CNT_W-1:0]   cnt_r;
  logic [NODE_W-1:0]  low_r;
  logic [CNT_W-1:0]   k_r;

  // close walk, write-back stage and forwarding of the last write
  logic               s1_v_r;
  logic [NODE_W-1:0]  s1_a_r;
  logic [REACH_W-1:0] s1_r_r;
  logic               fwd_v_r;
  logic [NODE_W-1:0]  fwd_a_r;
  logic [REACH_W-1:0] fwd_d_r;

  // emission
  logic [INNER_W-1:0] emit_node_r;
  logic [PTR_W-1:0]   ptr_r;
  logic               done_r;
  logic [WIDE_W-1:0]  inc_r;
  logic [WIDE_W-1:0]  row_base_r;
  logic [DOFS_W-1:0]  j_r;

  logic               out_valid_r;
  out_req_t           out_r;

  // ------------------------------------------------------- derived values
  logic [INNER_W-1:0] lim;
  logic [DOFS_W-1:0]  d_eff;
  logic               in_acc, is_entry, is_emit;
  logic               slot_free, out_load;
  logic               cl_go, cl_ok;
  logic [NODE_W-1:0]  cl_node;
  logic [REACH_W-1:0] cl_old, cl_new;
  logic [NODE_W-1:0]  low_nxt;
  logic               j_last, node_last;
  logic [WIDE_W-1:0]  row_full;
  out_req_t           out_nxt;

  assign lim   = eff_inner(inner_nodes_r);
  assign d_eff = eff_dofs(dofs_r);

  assign in_acc   = in_valid && !in_stall;
  assign is_entry = in_acc && !in_data.action;
  assign is_emit  = in_acc && in_data.action;

  // new lowest node including the entry now taken (dropped entries do not count)
  always_comb begin
    low_nxt = low_r;
    if (cnt_r < CNT_W'(ELEMENT_NODES) && in_data.node_index < low_r) begin
      low_nxt = in_data.node_index;
    end
  end

  // close walk, read side: pick the buffered node and check it is an inner node
  assign cl_go   = (state_r == ST_CLOSE) && (k_r < cnt_r);
  assign cl_node = elem_buf[k_r[ELEM_W-1:0]];
  assign cl_ok   = ({1'b0, cl_node} < lim) && (cl_node >= low_r);

  // close walk, write side: forward the write of the previous cycle
  always_comb begin
    cl_old = mem_rdata_r;
    if (fwd_v_r && fwd_a_r == s1_a_r) cl_old = fwd_d_r;
    cl_new = (s1_r_r > cl_old) ? s1_r_r : cl_old;
  end

  assign j_last    = (j_r == d_eff - DOFS_W'(1));
  assign node_last = ((emit_node_r + INNER_W'(1)) >= lim);
  assign row_full  = row_base_r + WIDE_W'(j_r);

  // ------------------------------------------------------------ next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == {NODE_W{1'b1}}) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (is_entry && in_data.element_end) begin
          state_nxt = ST_CLOSE;
        end else if (is_emit && !done_r) begin
          state_nxt = (emit_node_r < lim) ? ST_EM_READ : ST_EM_LAST;
        end
      end
      ST_CLOSE: begin
        if (k_r >= cnt_r) state_nxt = ST_IDLE;
      end
      ST_EM_READ: state_nxt = ST_EM_MUL;
      ST_EM_MUL:  state_nxt = ST_EM_ROW;
      ST_EM_ROW: begin
        if (slot_free && j_last) state_nxt = node_last ? ST_EM_LAST : ST_IDLE;
      end
      ST_EM_LAST: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------- outputs
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    slot_free = !out_valid_r || !out_stall;
    out_load  = slot_free && (state_r == ST_EM_ROW || state_r == ST_EM_LAST);

    mem_re = cl_go || (state_r == ST_EM_READ);
    mem_ra = (state_r == ST_EM_READ) ? emit_node_r[NODE_W-1:0] : cl_node;

    mem_we = (state_r == ST_CLEAR) || s1_v_r;
    mem_wa = (state_r == ST_CLEAR) ? clr_r : s1_a_r;
    mem_wd = (state_r == ST_CLEAR) ? '0 : cl_new;

    // build the row or closing request
    out_nxt = '0;
    if (state_r == ST_EM_LAST) begin
      out_nxt.row_pointer = sat_add(ptr_r, WIDE_W'(1));
      out_nxt.dof_row     = ROW_W'(WIDE_W'(lim) * WIDE_W'(d_eff));
      out_nxt.last        = 1'b1;
    end else begin
      out_nxt.row_pointer = (row_full == '0) ? '0 : sat_add(ptr_r, inc_r + WIDE_W'(j_r));
      out_nxt.dof_row     = row_full[ROW_W-1:0];
      out_nxt.last        = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------- memory
  always_ff @(posedge clk) begin
    if (mem_we) reach_mem[mem_wa] <= mem_wd;
    if (mem_re) mem_rdata_r <= reach_mem[mem_ra];
  end

  // hold the node entries of the current element
  always_ff @(posedge clk) begin
    if (is_entry && cnt_r < CNT_W'(ELEMENT_NODES)) begin
      elem_buf[cnt_r[ELEM_W-1:0]] <= in_data.node_index;
    end
  end

  // -------------------------------------------------------- control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      inner_nodes_r <= INNER_W'(1);
      dofs_r        <= DOFS_W'(3);
      clr_r         <= '0;
      cnt_r         <= '0;
      low_r         <= {NODE_W{1'b1}};
      k_r           <= '0;
      s1_v_r        <= 1'b0;
      fwd_v_r       <= 1'b0;
      emit_node_r   <= '0;
      ptr_r         <= '0;
      done_r        <= 1'b0;
      j_r           <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_INNER_NODES:   inner_nodes_r <= cfg_wdata[INNER_W-1:0];
          REG_DOFS_PER_NODE: dofs_r        <= cfg_wdata[DOFS_W-1:0];
          default: ;
        endcase
      end

      if (state_r == ST_CLEAR) clr_r <= clr_r + NODE_W'(1);

      // take a node entry; drop it when the element is already full
      if (is_entry) begin
        low_r <= low_nxt;
        if (cnt_r < CNT_W'(ELEMENT_NODES)) cnt_r <= cnt_r + CNT_W'(1);
        k_r <= '0;
      end

      // advance the close walk; restart the element when it drains
      s1_v_r <= cl_go && cl_ok;
      if (cl_go) k_r <= k_r + CNT_W'(1);
      if (state_r == ST_CLOSE && k_r >= cnt_r) begin
        cnt_r <= '0;
        low_r <= {NODE_W{1'b1}};
      end
      fwd_v_r <= s1_v_r;

      if (state_r == ST_EM_MUL) j_r <= '0;

      if (out_load) begin
        ptr_r <= out_nxt.row_pointer;
        if (state_r == ST_EM_LAST) begin
          done_r <= 1'b1;
        end else begin
          j_r <= j_r + DOFS_W'(1);
          if (j_last) emit_node_r <= emit_node_r + INNER_W'(1);
        end
      end

      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // -------------------------------------------------------- payload state
  always_ff @(posedge clk) begin
    if (cl_go) begin
      s1_a_r <= cl_node;
      s1_r_r <= REACH_W'(cl_node - low_r);
    end
    if (s1_v_r) begin
      fwd_a_r <= s1_a_r;
      fwd_d_r <= cl_new;
    end
    if (state_r == ST_EM_MUL) begin
      inc_r      <= WIDE_W'(mem_rdata_r) * WIDE_W'(d_eff) + WIDE_W'(1);
      row_base_r <= WIDE_W'(emit_node_r) * WIDE_W'(d_eff);
    end
    if (out_load) out_r <= out_nxt;
  end

  // ------------------------------------------------------------ assertions
  a_no_close_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !s1_v_r)
    else $error("close write-back overlaps the clearing pass");

  a_done_after_closing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_nxt.last) |=> done_r)
    else $error("closing pointer sent without ending emission");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(ELEMENT_NODES))
    else $error("element count beyond buffer depth");

  a_no_rows_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (state_r != ST_EM_ROW && state_r != ST_EM_LAST))
    else $error("emission active after closing pointer");

endmodule
